[src/fte_pkg.sv]
package fte_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int MAX_FIRE  = 16;
	localparam int QDEPTH    = 2;

	localparam logic [2:0]  ACT_STOP_REC = 3'd2;
	localparam logic [30:0] LATE_MAX     = '1;

	typedef enum logic [1:0] {
		FN_SCHED      = 2'd0,
		FN_CANCEL     = 2'd1,
		FN_CANCEL_ALL = 2'd2,
		FN_PROCESS    = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  action;
		logic [47:0] target_frame;
		logic [31:0] cancel_id;
		logic [47:0] buffer_start;
		logic [15:0] frame_count;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic        fired;
		logic [31:0] event_id;
		logic [2:0]  fired_action;
		logic [47:0] fired_target;
		logic [30:0] lateness;
		logic        last;
	} rsp_t;

	typedef struct packed {
		func_t       func;
		logic [2:0]  action;
		logic [47:0] target;
		logic [31:0] cancel_id;
		logic [47:0] bstart;
		logic [48:0] bend;
	} cmd_t;

	typedef struct packed {
		logic [31:0] id;
		logic [2:0]  kind;
		logic [47:0] due;
	} slot_t;

endpackage

[src/fte_front.sv]
module fte_front import fte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t           queue_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;
	cmd_t           cmd_in;

	assign req_stall = (cnt_q == CW'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign push      = req_valid && !req_stall;
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_comb begin
		cmd_in.func      = func_t'(req.func);
		cmd_in.action    = req.action;
		cmd_in.target    = req.target_frame;
		cmd_in.cancel_id = req.cancel_id;
		cmd_in.bstart    = req.buffer_start;
		cmd_in.bend      = {1'b0, req.buffer_start} + {33'd0, req.frame_count};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/fte_back.sv]
module fte_back import fte_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(MAX_FIRE + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t          st_q;
	cmd_t            cmd_q;
	logic [SLOTS-1:0] pend_q;
	slot_t           mem [SLOTS];
	slot_t           rd_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   rd_addr;
	logic [NW-1:0]   n_q;
	logic [31:0]     ctr_q;
	rsp_t            hold_q;
	rsp_t            out_q;
	logic            hold_fire_q;
	logic            out_valid_q;

	logic            take;
	logic            last_slot;
	logic            out_free;
	logic            pend_cur;
	logic [31:0]     new_id;
	logic [31:0]     ctr_next;
	logic            is_late;
	logic [47:0]     diff;
	logic [30:0]     late;
	logic            due;
	logic            sched_hit;
	logic            cancel_hit;
	logic            fire;
	logic            fire_block;
	logic            cap;
	logic            finish;
	logic            eval_go;
	logic            advance;
	logic            out_emit;
	rsp_t            fire_rsp;
	rsp_t            hold_d;
	rsp_t            out_d;

	assign cmd_pop   = (st_q == ST_IDLE);
	assign take      = (st_q == ST_IDLE) && cmd_valid;
	assign last_slot = (idx_q == IW'(SLOTS - 1));
	assign out_free  = !out_valid_q || !rsp_stall;
	assign pend_cur  = pend_q[idx_q];
	assign new_id    = (ctr_q == '0) ? 32'd1 : ctr_q;
	assign ctr_next  = (ctr_q == '0) ? 32'd2 : ctr_q + 32'd1;

	assign is_late = (rd_q.due < cmd_q.bstart);
	assign diff    = cmd_q.bstart - rd_q.due;
	assign late    = !is_late ? '0 : ((diff[47:31] != '0) ? LATE_MAX : diff[30:0]);
	assign due     = pend_cur && ((rd_q.kind == ACT_STOP_REC) ? is_late :
			({1'b0, rd_q.due} <= cmd_q.bend));

	assign sched_hit  = (cmd_q.func == FN_SCHED) && !pend_cur;
	assign cancel_hit = (cmd_q.func == FN_CANCEL) && (cmd_q.cancel_id != '0) && pend_cur &&
			(rd_q.id == cmd_q.cancel_id);
	assign fire       = (cmd_q.func == FN_PROCESS) && due;
	assign fire_block = fire && hold_fire_q && !out_free;
	assign cap        = fire && (n_q == NW'(MAX_FIRE - 1));
	assign finish     = sched_hit || cancel_hit || cap || last_slot;
	assign eval_go    = (st_q == ST_EVAL) && !fire_block;
	assign advance    = eval_go && !finish;
	assign out_emit   = (eval_go && fire && hold_fire_q) || ((st_q == ST_FLUSH) && out_free);

	always_comb begin
		if (advance) begin
			rd_addr = idx_q + 1'b1;
		end else if (st_q == ST_IDLE) begin
			rd_addr = '0;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_comb begin
		fire_rsp              = '0;
		fire_rsp.ok           = 1'b1;
		fire_rsp.fired        = 1'b1;
		fire_rsp.event_id     = rd_q.id;
		fire_rsp.fired_action = rd_q.kind;
		fire_rsp.fired_target = rd_q.due;
		fire_rsp.lateness     = late;
		hold_d                = hold_q;
		if (take) begin
			hold_d    = '0;
			hold_d.ok = (cmd.func == FN_CANCEL_ALL) || (cmd.func == FN_PROCESS);
		end else if (eval_go) begin
			if (sched_hit) begin
				hold_d.ok       = 1'b1;
				hold_d.event_id = new_id;
			end
			if (cancel_hit) begin
				hold_d.ok = 1'b1;
			end
			if (fire) begin
				hold_d = fire_rsp;
			end
		end
		out_d                 = hold_q;
		out_d.last            = (st_q == ST_FLUSH);
	end

	always_ff @(posedge clk) begin
		if (eval_go && sched_hit) begin
			mem[idx_q] <= '{id: new_id, kind: cmd_q.action, due: cmd_q.target};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
		end
		hold_q <= hold_d;
		if (out_emit) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pend_q      <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			ctr_q       <= 32'd1;
			hold_fire_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q       <= '0;
						n_q         <= '0;
						hold_fire_q <= 1'b0;
						if (cmd.func == FN_CANCEL_ALL) begin
							pend_q <= '0;
							st_q   <= ST_FLUSH;
						end else begin
							st_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (!fire_block) begin
						if (sched_hit) begin
							pend_q[idx_q] <= 1'b1;
							ctr_q         <= ctr_next;
						end
						if (cancel_hit || fire) begin
							pend_q[idx_q] <= 1'b0;
						end
						if (fire) begin
							hold_fire_q <= 1'b1;
							n_q         <= n_q + 1'b1;
						end
						if (finish) begin
							st_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_hold_fire_process: assert property (@(posedge clk) disable iff (!arst_n)
		hold_fire_q |-> (cmd_q.func == FN_PROCESS))
		else $error("held fire outside a process transaction");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_FIRE))
		else $error("fire count beyond cap");

	a_sched_claims: assert property (@(posedge clk) disable iff (!arst_n)
		eval_go && sched_hit |=> pend_q[$past(idx_q)])
		else $error("scheduled slot not pending");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FLUSH) && out_free |=> out_valid_q && out_q.last)
		else $error("final result not marked last");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.fired |-> out_q.ok && (out_q.event_id != '0))
		else $error("fired result without ok or id");

endmodule

[src/frame_timed_event_table.sv]
// Timed event table with SLOTS slots.
// Request channel req_valid/req_stall/req carries one command per transaction:
// schedule, cancel, cancel all or process buffer. Response channel
// rsp_valid/rsp_stall/rsp returns one result per transaction for schedule,
// cancel and cancel all, and for process buffer one result per fired event
// (at most MAX_FIRE) or a single empty result; last marks the final one.
// A two-entry command queue sits in front of the slot sequencer, so new
// commands are taken while a result waits on rsp_stall.
// The sequencer walks the slots one per cycle when not held, from a registered
// slot memory: schedule and cancel stop at the first hit, process buffer visits
// every slot until the walk ends or the MAX_FIRE-th event fires.
// A command passes through the idle, walk and flush states; cancel all goes
// from idle straight to flush.
// A later fired event holds the walk while the output is full and stalled.
// Reset marks every slot empty, sets the id counter to 1 and empties the queue.
// While rsp_stall is high the result holds and the sequencer halts at flush or
// on a later fired event; the queue then fills and req_stall rises.
module frame_timed_event_table import fte_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	fte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	fte_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[tb/tb_frame_timed_event_table.sv]
module tb_frame_timed_event_table import fte_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int N_RANDOM   = 400;
	localparam int TAIL_WAIT  = SLOTS + 10;
	localparam int LIMIT      = 600000;

	typedef enum logic [1:0] {
		SL_EMPTY     = 2'd0,
		SL_PENDING   = 2'd1,
		SL_CANCELLED = 2'd2,
		SL_FIRED     = 2'd3
	} slot_state_e;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	frame_timed_event_table #(.SLOTS(SLOTS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// shadow of the event table
	slot_state_e ev_state [SLOTS];
	logic [31:0] ev_id    [SLOTS];
	logic [2:0]  ev_act   [SLOTS];
	logic [47:0] ev_due   [SLOTS];
	logic [31:0] next_id;

	rsp_t step_rsp [$];
	rsp_t awaited_rsp [$];

	bit   cur_typed;
	rsp_t cur_want;

	int unsigned n_bad = 0;
	int unsigned cycles = 0;

	function automatic rsp_t plain_rsp(logic ok, logic [31:0] id);
		rsp_t p;
		p          = '0;
		p.ok       = ok;
		p.event_id = id;
		p.last     = 1'b1;
		return p;
	endfunction

	function automatic void event_table_step(input req_t r);
		rsp_t        p;
		logic [48:0] bend;
		logic [47:0] diff;
		logic [31:0] id;
		bit          due;
		bit          hit;
		int          nfire;
		step_rsp.delete();
		p   = plain_rsp(1'b1, '0);
		hit = 1'b0;
		case (func_t'(r.func))
			FN_SCHED: begin
				p.ok = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!hit && ev_state[i] != SL_PENDING) begin
						hit = 1'b1;
						id = next_id;
						next_id++;
						if (id == '0) begin
							id = next_id;
							next_id++;
						end
						ev_id[i]    = id;
						ev_act[i]   = r.action;
						ev_due[i]   = r.target_frame;
						ev_state[i] = SL_PENDING;
						p.ok        = 1'b1;
						p.event_id  = id;
					end
				end
				step_rsp.push_back(p);
			end
			FN_CANCEL: begin
				p.ok = 1'b0;
				if (r.cancel_id != '0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!hit && ev_state[i] == SL_PENDING && ev_id[i] == r.cancel_id) begin
							hit = 1'b1;
							ev_state[i] = SL_CANCELLED;
							p.ok = 1'b1;
						end
					end
				end
				step_rsp.push_back(p);
			end
			FN_CANCEL_ALL: begin
				for (int i = 0; i < SLOTS; i++)
					if (ev_state[i] == SL_PENDING)
						ev_state[i] = SL_CANCELLED;
				step_rsp.push_back(p);
			end
			default: begin
				bend  = {1'b0, r.buffer_start} + r.frame_count;
				nfire = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (nfire < MAX_FIRE && ev_state[i] == SL_PENDING) begin
						if (ev_act[i] == ACT_STOP_REC)
							due = ev_due[i] < r.buffer_start;
						else
							due = {1'b0, ev_due[i]} <= bend;
						if (due) begin
							p              = '0;
							p.ok           = 1'b1;
							p.fired        = 1'b1;
							p.event_id     = ev_id[i];
							p.fired_action = ev_act[i];
							p.fired_target = ev_due[i];
							if (ev_due[i] < r.buffer_start) begin
								diff = r.buffer_start - ev_due[i];
								p.lateness = (diff > {17'd0, LATE_MAX}) ? LATE_MAX : diff[30:0];
							end
							step_rsp.push_back(p);
							ev_state[i] = SL_EMPTY;
							nfire++;
						end
					end
				end
				if (nfire == 0)
					step_rsp.push_back(plain_rsp(1'b1, '0));
				else
					step_rsp[nfire-1].last = 1'b1;
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_bad++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t w;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				$error("response transaction with nothing awaited");
				n_bad++;
			end else begin
				w = awaited_rsp.pop_front();
				check_field("ok", w.ok, rsp.ok);
				check_field("fired", w.fired, rsp.fired);
				check_field("event_id", w.event_id, rsp.event_id);
				check_field("fired_action", w.fired_action, rsp.fired_action);
				check_field("fired_target", w.fired_target, rsp.fired_target);
				check_field("lateness", w.lateness, rsp.lateness);
				check_field("last", w.last, rsp.last);
			end
		end
		if (arst_n && req_valid && !req_stall) begin
			event_table_step(req);
			if (cur_typed)
				awaited_rsp.push_back(cur_want);
			else
				foreach (step_rsp[i])
					awaited_rsp.push_back(step_rsp[i]);
		end
	end

	// receiver: stall runs and free runs of random length
	int stall_run = 0;
	bit stall_now = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_run == 0) begin
				stall_now = ($urandom_range(0, 2) == 0);
				stall_run = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 40);
			end
			stall_run--;
			rsp_stall <= stall_now;
		end
	end

	// sender side
	logic [47:0] frame_now;
	bit          fill_mode;
	int          burst_left = 0;

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	function automatic req_t mk_req(func_t f, logic [2:0] a, logic [47:0] t,
	                                logic [31:0] cid, logic [47:0] bs, logic [15:0] fc);
		req_t r;
		r.func         = f;
		r.action       = a;
		r.target_frame = t;
		r.cancel_id    = cid;
		r.buffer_start = bs;
		r.frame_count  = fc;
		return r;
	endfunction

	function automatic req_t next_random_req();
		req_t r;
		int   pick;
		int   sel;
		r.func         = 2'(func_t'($urandom_range(0, 3)));
		r.action       = 3'($urandom());
		r.target_frame = rand48();
		r.cancel_id    = $urandom();
		r.buffer_start = rand48();
		r.frame_count  = 16'($urandom());
		pick = fill_mode ? $urandom_range(0, 69) : $urandom_range(0, 99);
		if (fill_mode && pick >= 60)
			pick = pick + 30;
		if (pick < 45) begin
			r.func = FN_SCHED;
			r.action = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 4))
			                                          : 3'($urandom_range(0, 7));
			sel = $urandom_range(0, 99);
			if (sel < 15)
				r.target_frame = frame_now + {8'd1, 40'd0} + 48'($urandom_range(0, 9999));
			else if (sel >= 90)
				r.target_frame = rand48();
			else
				r.target_frame = frame_now + 48'($urandom_range(0, 3500)) - 48'd500;
		end else if (pick < 60) begin
			r.func = FN_CANCEL;
			sel = $urandom_range(0, 9);
			if (sel < 7)
				r.cancel_id = next_id - 32'($urandom_range(1, 16));
			else if (sel == 7)
				r.cancel_id = '0;
		end else if (pick < 63) begin
			r.func = FN_CANCEL_ALL;
		end else begin
			r.func = FN_PROCESS;
			sel = $urandom_range(0, 99);
			if (sel < 5)
				r.frame_count = 16'hFFFF;
			else if (sel < 90)
				r.frame_count = 16'($urandom_range(0, 1024));
			if ($urandom_range(0, 99) >= 5)
				r.buffer_start = frame_now;
			frame_now = r.buffer_start + r.frame_count;
		end
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic push_req(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	localparam logic [47:0] F_MAX = '1;
	localparam logic [15:0] C_MAX = '1;

	initial begin
		dir_row_t rows [$];
		req_t     r;

		for (int i = 0; i < SLOTS; i++) begin
			ev_state[i] = SL_EMPTY;
			ev_id[i]    = '0;
			ev_act[i]   = '0;
			ev_due[i]   = '0;
		end
		next_id   = 32'd1;
		cur_typed = 1'b0;
		cur_want  = '0;
		frame_now = 48'($urandom_range(0, 100000));
		fill_mode = 1'b0;

		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd0)});
		rows.push_back('{mk_req(FN_CANCEL, 3'd0, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b0, 32'd0)});
		rows.push_back('{mk_req(FN_CANCEL, 3'd0, '0, '1, '0, '0), 1'b1,
			plain_rsp(1'b0, 32'd0)});
		rows.push_back('{mk_req(FN_CANCEL_ALL, 3'd0, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd0)});
		rows.push_back('{mk_req(FN_SCHED, 3'd0, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd1)});
		rows.push_back('{mk_req(FN_SCHED, ACT_STOP_REC, 48'd100, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd2)});
		rows.push_back('{mk_req(FN_SCHED, 3'd7, F_MAX, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd3)});
		rows.push_back('{mk_req(FN_SCHED, 3'd4, 48'd50, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd4)});
		rows.push_back('{mk_req(FN_CANCEL, 3'd0, '0, 32'd4, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd0)});
		rows.push_back('{mk_req(FN_CANCEL, 3'd0, '0, 32'd4, '0, '0), 1'b1,
			plain_rsp(1'b0, 32'd0)});
		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, 48'd100, '0), 1'b0, '0});
		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, 48'd101, '0), 1'b0, '0});
		rows.push_back('{mk_req(FN_SCHED, 3'd1, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd5)});
		rows.push_back('{mk_req(FN_SCHED, 3'd3, 48'd200, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd6)});
		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, F_MAX, C_MAX), 1'b0, '0});
		rows.push_back('{mk_req(FN_SCHED, ACT_STOP_REC, F_MAX, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd7)});
		rows.push_back('{mk_req(FN_SCHED, 3'd5, 48'd1000, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd8)});
		rows.push_back('{mk_req(FN_SCHED, 3'd6, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd9)});
		rows.push_back('{mk_req(FN_CANCEL_ALL, 3'd0, '0, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd0)});
		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, F_MAX, C_MAX), 1'b1,
			plain_rsp(1'b1, 32'd0)});
		rows.push_back('{mk_req(FN_SCHED, ACT_STOP_REC, 48'd10, '0, '0, '0), 1'b1,
			plain_rsp(1'b1, 32'd10)});
		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, 48'd10, C_MAX), 1'b1,
			plain_rsp(1'b1, 32'd0)});
		rows.push_back('{mk_req(FN_PROCESS, 3'd0, '0, '0, 48'd11, '0), 1'b0, '0});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			pace();
			cur_typed = rows[i].typed;
			cur_want  = rows[i].want;
			push_req(rows[i].r);
		end

		cur_typed = 1'b0;
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 40 == 0)
				fill_mode = ($urandom_range(0, 2) == 0);
			if (k == N_RANDOM / 2) begin
				// hold off until every awaited response is back
				req_valid <= 1'b0;
				do @(negedge clk); while (awaited_rsp.size() != 0);
			end else begin
				pace();
			end
			r = next_random_req();
			push_req(r);
		end

		req_valid <= 1'b0;
		do @(negedge clk); while (awaited_rsp.size() != 0);
		repeat (TAIL_WAIT) @(posedge clk);

		if (n_bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
